FILE: sv/oml_pkg.sv
// types and constants shared by the order maintenance list
// no dependencies
package oml_pkg;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_LISTED     = 2'd1;
  localparam logic [1:0] ST_NOT_LISTED = 2'd2;
  localparam logic [1:0] ST_BAD_POS    = 2'd3;

  localparam logic [63:0] LABEL_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LABEL_MIN = 64'h0;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  vertex;
    logic [10:0] position;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        present;
    logic [63:0] order_label;
    logic [10:0] successor;
    logic [10:0] predecessor;
    logic        relabeled;
  } rsp_t;

  typedef struct packed {
    logic cap;
    logic dec;
    logic ppos;
    logic link1;
    logic link2;
    logic lrd;
    logic gap_wr;
    logic div_start;
    logic walk_init;
    logic walk_wr;
    logic walk_adv;
    logic rmv;
    logic clr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic ins_go;
    logic need_ppos;
    logic rm_go;
    logic relab_go;
    logic div_busy;
    logic walk_done;
    logic out_free;
  } stat_t;

endpackage

FILE: sv/oml_div.sv
// restoring divider: all-ones 64-bit dividend over a narrow divisor, one bit a cycle
// no dependencies
module oml_div #(
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [63:0]   quot
);

  logic          busy_r, busy_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [63:0]   q_r, q_nxt;
  logic [DW:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    trial    = {rem_r, 1'b1};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'd0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DW'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

FILE: sv/oml_ctrl.sv
// request sequencer of the order maintenance list
// depends on oml_pkg
module oml_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  oml_pkg::stat_t st,
  output oml_pkg::cmd_t  cmd
);

  typedef enum logic [14:0] {
    S_CLR   = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_LOOK  = 15'b000000000000100,
    S_DEC   = 15'b000000000001000,
    S_PPOS  = 15'b000000000010000,
    S_LINK1 = 15'b000000000100000,
    S_LINK2 = 15'b000000001000000,
    S_LRD   = 15'b000000010000000,
    S_GAP   = 15'b000000100000000,
    S_DIV   = 15'b000001000000000,
    S_WWR   = 15'b000010000000000,
    S_WNX   = 15'b000100000000000,
    S_RMV   = 15'b001000000000000,
    S_RPT   = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: state_nxt = S_DEC;
      S_DEC: begin
        cmd.dec = 1'b1;
        if (st.ins_go) state_nxt = st.need_ppos ? S_PPOS : S_LINK1;
        else if (st.rm_go) state_nxt = S_RMV;
        else state_nxt = S_RPT;
      end
      S_PPOS: begin
        cmd.ppos  = 1'b1;
        state_nxt = S_LINK1;
      end
      S_LINK1: begin
        cmd.link1 = 1'b1;
        state_nxt = S_LINK2;
      end
      S_LINK2: begin
        cmd.link2 = 1'b1;
        state_nxt = S_LRD;
      end
      S_LRD: begin
        cmd.lrd   = 1'b1;
        state_nxt = S_GAP;
      end
      S_GAP: begin
        if (st.relab_go) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.gap_wr = 1'b1;
          state_nxt  = S_RPT;
        end
      end
      S_DIV: begin
        if (!st.div_busy) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WWR;
        end
      end
      S_WWR: begin
        cmd.walk_wr = 1'b1;
        state_nxt   = S_WNX;
      end
      S_WNX: begin
        cmd.walk_adv = 1'b1;
        state_nxt    = st.walk_done ? S_LRD : S_WWR;
      end
      S_RMV: begin
        cmd.rmv   = 1'b1;
        state_nxt = S_RPT;
      end
      S_RPT: state_nxt = S_OUT;
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

FILE: sv/oml_dp.sv
// link, label and membership memories with the request registers and result register
// depends on oml_pkg and oml_div
module oml_dp #(
  parameter int NUM_ENTRIES = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  oml_pkg::req_t  in_req,
  input  logic           out_stall,
  output logic           out_valid,
  output oml_pkg::rsp_t  out_rsp,
  input  oml_pkg::cmd_t  cmd,
  output oml_pkg::stat_t st
);

  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int LW = $clog2(NUM_ENTRIES + 1);
  localparam int XW = (LW > 11) ? LW : 11;
  localparam logic [LW-1:0] NIL = LW'(NUM_ENTRIES);
  localparam logic [XW-1:0] NIL_X = XW'(NUM_ENTRIES);

  logic          pres_mem [NUM_ENTRIES];
  logic [LW-1:0] next_mem [NUM_ENTRIES];
  logic [LW-1:0] prev_mem [NUM_ENTRIES];
  logic [63:0]   lab_mem  [NUM_ENTRIES];

  oml_pkg::req_t req_r;
  logic [LW-1:0] head_r, head_nxt, tail_r, tail_nxt, cnt_r, cnt_nxt;
  logic [LW-1:0] newp_r, newp_nxt, newn_r, newn_nxt;
  logic [LW-1:0] cur_r, cur_nxt, guard_r, guard_nxt;
  logic [63:0]   val_r, val_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          relab_r;
  logic [IW-1:0] clr_r;
  logic          out_valid_r;
  oml_pkg::rsp_t out_rsp_r;

  logic          pres_a_q, pres_b_q;
  logic [LW-1:0] next_q, prev_q;
  logic [63:0]   lab_a_q, lab_b_q;

  logic [XW-1:0] v_x, p_x;
  logic [IW-1:0] vidx, pidx;
  logic [LW-1:0] v_l, p_l;
  logic          v_ok, listed, pos_nil, pos_ok, list_empty;
  logic [63:0]   lo, hi, mid;
  logic          gap_empty;
  logic          div_busy;
  logic [63:0]   step;

  logic [IW-1:0] next_ra, prev_ra, lab_ra;
  logic          pres_we, pres_wd;
  logic [IW-1:0] pres_wa;
  logic          next_we, prev_we, lab_we;
  logic [IW-1:0] next_wa, prev_wa, lab_wa;
  logic [LW-1:0] next_wd, prev_wd;
  logic [63:0]   lab_wd;
  logic [XW-1:0] succ_x, pred_x;

  assign v_x  = XW'(req_r.vertex);
  assign p_x  = XW'(req_r.position);
  assign vidx = v_x[IW-1:0];
  assign pidx = p_x[IW-1:0];
  assign v_l  = v_x[LW-1:0];
  assign p_l  = p_x[LW-1:0];

  assign v_ok       = v_x < NIL_X;
  assign listed     = v_ok && pres_a_q;
  assign pos_nil    = p_x == NIL_X;
  assign pos_ok     = pos_nil || (p_x < NIL_X && pres_b_q);
  assign list_empty = (head_r == NIL) || (tail_r == NIL);

  assign lo        = (newp_r == NIL) ? oml_pkg::LABEL_MIN : lab_a_q;
  assign hi        = (newn_r == NIL) ? oml_pkg::LABEL_MAX : lab_b_q;
  assign mid       = lo + ((hi - lo) >> 1);
  assign gap_empty = (hi == lo) || (hi == lo + 64'd1);

  oml_div #(.DW(LW + 1)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .divisor ({1'b0, cnt_r} + (LW + 1)'(1)),
    .busy    (div_busy),
    .quot    (step)
  );

  always_comb begin
    status_nxt = status_r;
    if (req_r.req_type == oml_pkg::REQ_INSERT) begin
      if (listed) status_nxt = oml_pkg::ST_LISTED;
      else if (!v_ok) status_nxt = oml_pkg::ST_NOT_LISTED;
      else if (!pos_ok) status_nxt = oml_pkg::ST_BAD_POS;
      else status_nxt = oml_pkg::ST_OK;
    end else begin
      status_nxt = listed ? oml_pkg::ST_OK : oml_pkg::ST_NOT_LISTED;
    end
  end

  always_comb begin
    st.clr_done  = clr_r == IW'(NUM_ENTRIES - 1);
    st.ins_go    = (req_r.req_type == oml_pkg::REQ_INSERT) && (status_nxt == oml_pkg::ST_OK);
    st.need_ppos = !list_empty && !pos_nil;
    st.rm_go     = (req_r.req_type == oml_pkg::REQ_REMOVE) && listed;
    st.relab_go  = gap_empty && !relab_r;
    st.div_busy  = div_busy;
    st.walk_done = (next_q == NIL) || (guard_r == LW'(NUM_ENTRIES - 1));
    st.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    newp_nxt  = newp_r;
    newn_nxt  = newn_r;
    cur_nxt   = cur_r;
    guard_nxt = guard_r;
    val_nxt   = val_r;
    if (cmd.dec) begin
      newp_nxt = prev_q;
      newn_nxt = next_q;
    end
    if (cmd.link1) begin
      if (list_empty) begin
        newp_nxt = NIL;
        newn_nxt = NIL;
      end else if (pos_nil) begin
        newp_nxt = tail_r;
        newn_nxt = NIL;
      end else begin
        newp_nxt = prev_q;
        newn_nxt = p_l;
      end
      cnt_nxt = cnt_r + LW'(1);
    end
    if (cmd.link2) begin
      if (newp_r == NIL) head_nxt = v_l;
      if (newn_r == NIL) tail_nxt = v_l;
    end
    if (cmd.rmv) begin
      if (newp_r == NIL) head_nxt = newn_r;
      if (newn_r == NIL) tail_nxt = newp_r;
      if (cnt_r != '0) cnt_nxt = cnt_r - LW'(1);
    end
    if (cmd.walk_init) begin
      cur_nxt   = head_r;
      guard_nxt = '0;
      val_nxt   = oml_pkg::LABEL_MIN + step;
    end
    if (cmd.walk_adv) begin
      cur_nxt   = next_q;
      guard_nxt = guard_r + LW'(1);
      val_nxt   = val_r + step;
    end
  end

  always_comb begin
    next_ra = cmd.walk_wr ? cur_r[IW-1:0] : vidx;
    prev_ra = cmd.ppos ? pidx : vidx;
    lab_ra  = cmd.lrd ? newp_r[IW-1:0] : vidx;

    pres_we = cmd.clr || cmd.link1 || cmd.rmv;
    pres_wa = cmd.clr ? clr_r : vidx;
    pres_wd = cmd.link1;

    next_we = 1'b0;
    next_wa = vidx;
    next_wd = newn_nxt;
    prev_we = 1'b0;
    prev_wa = vidx;
    prev_wd = newp_nxt;
    if (cmd.link1) begin
      next_we = 1'b1;
      prev_we = 1'b1;
    end
    if (cmd.link2) begin
      next_we = newp_r != NIL;
      next_wa = newp_r[IW-1:0];
      next_wd = v_l;
      prev_we = newn_r != NIL;
      prev_wa = newn_r[IW-1:0];
      prev_wd = v_l;
    end
    if (cmd.rmv) begin
      next_we = newp_r != NIL;
      next_wa = newp_r[IW-1:0];
      next_wd = newn_r;
      prev_we = newn_r != NIL;
      prev_wa = newn_r[IW-1:0];
      prev_wd = newp_r;
    end

    lab_we = cmd.gap_wr || cmd.walk_wr;
    lab_wa = cmd.walk_wr ? cur_r[IW-1:0] : vidx;
    lab_wd = cmd.walk_wr ? val_r : mid;
  end

  always_ff @(posedge clk) begin
    if (pres_we) pres_mem[pres_wa] <= pres_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (lab_we) lab_mem[lab_wa] <= lab_wd;
    pres_a_q <= pres_mem[vidx];
    pres_b_q <= pres_mem[pidx];
    next_q   <= next_mem[next_ra];
    prev_q   <= prev_mem[prev_ra];
    lab_a_q  <= lab_mem[lab_ra];
    lab_b_q  <= lab_mem[newn_r[IW-1:0]];
  end

  assign succ_x = XW'(listed ? next_q : NIL);
  assign pred_x = XW'(listed ? prev_q : NIL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NIL;
      tail_r      <= NIL;
      cnt_r       <= '0;
      clr_r       <= '0;
      relab_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      if (cmd.clr) clr_r <= clr_r + IW'(1);
      if (cmd.cap) relab_r <= 1'b0;
      else if (cmd.div_start) relab_r <= 1'b1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
    if (cmd.cap) req_r <= in_req;
    if (cmd.dec) status_r <= status_nxt;
    newp_r  <= newp_nxt;
    newn_r  <= newn_nxt;
    cur_r   <= cur_nxt;
    guard_r <= guard_nxt;
    val_r   <= val_nxt;
    if (cmd.out_load) begin
      out_rsp_r.status      <= status_r;
      out_rsp_r.present     <= listed;
      out_rsp_r.order_label <= listed ? lab_a_q : 64'd0;
      out_rsp_r.successor   <= succ_x[10:0];
      out_rsp_r.predecessor <= pred_x[10:0];
      out_rsp_r.relabeled   <= relab_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

FILE: sv/order_maintenance_list.sv
// order maintenance list: ordered doubly linked list of entries with 64-bit order labels
// top level; depends on oml_pkg, oml_ctrl, oml_dp
//
// usage:
//   in_req (req_type, vertex, position) is taken when in_valid is high and in_stall low.
//   each request gives one response on out_rsp, taken when out_valid is high and
//   out_stall low; responses come back in request order.
//   requests are handled one at a time by a sequencer over the link and label memories.
//   the next request is taken in the cycle after the response loads; an insert placed
//   before an entry takes an extra step that reads the predecessor of that entry.
//   an insert that finds no label gap adds a division of the label range by one more
//   than the entry count, then a walk from the head that relabels each listed entry.
//   the response register lets the next request be taken while a response is stalled;
//   a stalled response holds and the block waits with the next result until it is taken.
//   after reset the membership map is cleared one entry a cycle, all NUM_ENTRIES of them,
//   with in_stall high; the list is then empty.
module order_maintenance_list #(
  parameter int NUM_ENTRIES = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  oml_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_stall,
  output oml_pkg::rsp_t out_rsp
);

  oml_pkg::cmd_t  cmd;
  oml_pkg::stat_t st;

  oml_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  oml_dp #(.NUM_ENTRIES(NUM_ENTRIES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cmd       (cmd),
    .st        (st)
  );

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while a previous one is in progress");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.present |-> out_rsp.order_label == 64'd0)
    else $error("unlisted entry reported with a label");

  a_relabel_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.relabeled |-> out_rsp.status == oml_pkg::ST_OK && out_rsp.present)
    else $error("relabel flagged on a failed insert");

endmodule
